### rtl/core/taj_pkg.sv
package taj_pkg;

    localparam int unsigned MAX_NODES_DEF = 1024;
    localparam int unsigned DEPTH_W       = 10;
    localparam int unsigned NODE_W        = 10;
    localparam int unsigned LEN_W         = 11;
    localparam int unsigned STEP_W        = 11;
    localparam logic [DEPTH_W-1:0] DEPTH_MAX = 10'd1023;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;

    // one table entry: parent, jump pointer, depth
    typedef struct packed {
        logic [NODE_W-1:0]  parent;
        logic [NODE_W-1:0]  jump;
        logic [DEPTH_W-1:0] depth;
    } entry_t;

    localparam int unsigned ENTRY_W = $bits(entry_t);

endpackage

### rtl/core/taj_ram.sv
module taj_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/core/tree_ancestor_jump_query.sv
// channel | signals                                            | direction
// in      | in_valid, in_ready, cmd, first_node, second_node,  | into block
//         | step_count                                         |
// out     | out_valid, out_ready, common_ancestor, path_length,| out of block
//         | path_node, path_node_valid                         |
// a root insert writes its entry straight from idle; any other insert makes three dependent
// reads (parent, its jump, that jump's jump), each held through S_RD, then the write
// a query reads the entries of both nodes, climbs to equal depth, compares ancestors and,
// when the path node is valid, climbs again; every read goes through the single table memory
// reset clears the sequencer and the output valid flag only; tables hold garbage until written
// a waiting result holds a finished query in its last state; in_ready is high only when idle
module tree_ancestor_jump_query #(
    parameter int unsigned MAX_NODES = taj_pkg::MAX_NODES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        cmd,
    input  logic [9:0]  first_node,
    input  logic [9:0]  second_node,
    input  logic [10:0] step_count,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [9:0]  common_ancestor,
    output logic [10:0] path_length,
    output logic [9:0]  path_node,
    output logic        path_node_valid
);

    localparam int unsigned AW = $clog2(MAX_NODES);
    localparam int unsigned RW = $clog2(MAX_NODES + 1) + 1;

    // sequencer states: every read issues before S_RD and is consumed in the state after it
    typedef enum logic [15:0] {
        S_IDLE   = 16'h0001,
        S_RD     = 16'h0002,  // wait cycle for memory read
        S_INS_B  = 16'h0004,  // got parent entry
        S_INS_J  = 16'h0008,  // got parent's jump entry
        S_INS_JJ = 16'h0010,  // got jump-jump entry, write
        S_Q_A    = 16'h0020,  // got entry of a
        S_Q_B    = 16'h0040,  // got entry of b
        S_CL     = 16'h0080,  // climb: got entry of current u
        S_CLJ    = 16'h0100,  // climb: got jump entry of u
        S_LU     = 16'h0200,  // lca: got entry of u
        S_LV     = 16'h0400,  // lca: got entry of v
        S_LM     = 16'h0800,  // got entry of lca
        S_KICK   = 16'h1000,  // decide the path node climb
        S_DONE   = 16'h2000
    } state_t;

    typedef enum logic [1:0] {
        CL_EQ   = 2'd0,  // climb to equal depth inside lca
        CL_PATH = 2'd1   // final path node climb
    } climb_t;

    state_t state_reg, state_next, ret_reg, ret_next;
    climb_t cmode_reg, cmode_next;

    logic [9:0]  a_reg, a_next, b_reg, b_next;
    logic [10:0] k_reg, k_next;
    logic [9:0]  u_reg, u_next, v_reg, v_next;
    taj_pkg::entry_t eu_reg, eu_next, ev_reg, ev_next, ej_reg, ej_next;
    logic [9:0]  da_reg, da_next, db_reg, db_next;
    logic [10:0] ck_reg, ck_next;
    logic [RW-1:0] rnd_reg, rnd_next;
    logic [9:0]  m_reg, m_next;
    logic [10:0] plen_reg, plen_next;
    logic [9:0]  pn_reg, pn_next;
    logic        pv_reg, pv_next;

    logic        ov_reg, ov_next;
    logic [9:0]  oca_reg, oca_next, opn_reg, opn_next;
    logic [10:0] opl_reg, opl_next;
    logic        opv_reg, opv_next;

    logic                  we;
    logic [AW-1:0]         waddr, raddr;
    logic [AW-1:0]         raddr_reg;
    taj_pkg::entry_t       wdata, rdata;
    logic [taj_pkg::ENTRY_W-1:0] rdata_bits;

    assign rdata = taj_pkg::entry_t'(rdata_bits);

    taj_ram #(
        .WIDTH(taj_pkg::ENTRY_W),
        .DEPTH(MAX_NODES)
    ) u_tab (
        .clk  (clk),
        .we   (we),
        .waddr(waddr),
        .wdata(wdata),
        .raddr(raddr),
        .rdata(rdata_bits)
    );

    // node id reduced to a table address
    function automatic logic [AW-1:0] idx(input logic [9:0] n);
        logic [31:0] w;
        w = 32'(n) % MAX_NODES;
        return w[AW-1:0];
    endfunction

    assign in_ready        = (state_reg == S_IDLE);
    assign out_valid       = ov_reg;
    assign common_ancestor = oca_reg;
    assign path_length     = opl_reg;
    assign path_node       = opn_reg;
    assign path_node_valid = opv_reg;

    always_comb
    begin
        logic [10:0] gain;
        logic [11:0] twice;
        logic [11:0] sumd;
        logic [11:0] lenw;
        logic [9:0]  tmp;
        logic [9:0]  up;
        state_next = state_reg;
        ret_next   = ret_reg;
        cmode_next = cmode_reg;
        a_next = a_reg; b_next = b_reg; k_next = k_reg;
        u_next = u_reg; v_next = v_reg;
        eu_next = eu_reg; ev_next = ev_reg; ej_next = ej_reg;
        da_next = da_reg; db_next = db_reg; ck_next = ck_reg;
        rnd_next = rnd_reg; m_next = m_reg; plen_next = plen_reg;
        pn_next = pn_reg; pv_next = pv_reg;
        ov_next = ov_reg; oca_next = oca_reg; opl_next = opl_reg;
        opn_next = opn_reg; opv_next = opv_reg;
        we = 1'b0; waddr = idx(a_reg); wdata = '0; raddr = idx(u_reg);
        gain = '0; twice = '0; sumd = '0; lenw = '0; tmp = '0; up = '0;

        if (ov_reg && out_ready)
        begin
            ov_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    a_next = first_node;
                    b_next = second_node;
                    k_next = step_count;
                    if (cmd == taj_pkg::CMD_INSERT)
                    begin
                        if (idx(first_node) == idx(second_node))
                        begin
                            we    = 1'b1;
                            waddr = idx(first_node);
                            wdata = '{parent: first_node, jump: first_node, depth: '0};
                        end
                        else
                        begin
                            raddr = idx(second_node);
                            state_next = S_RD;
                            ret_next = S_INS_B;
                        end
                    end
                    else
                    begin
                        raddr = idx(first_node);
                        state_next = S_RD;
                        ret_next = S_Q_A;
                    end
                end
            end
            S_RD:
            begin
                // keep the address so the entry is still there next cycle
                raddr = raddr_reg;
                state_next = ret_reg;
            end
            S_INS_B:
            begin
                eu_next = rdata;
                raddr = idx(rdata.jump);
                state_next = S_RD;
                ret_next = S_INS_J;
            end
            S_INS_J:
            begin
                ev_next = rdata;
                raddr = idx(rdata.jump);
                state_next = S_RD;
                ret_next = S_INS_JJ;
            end
            S_INS_JJ:
            begin
                sumd  = 12'(eu_reg.depth) + 12'(rdata.depth);
                twice = {1'b0, ev_reg.depth, 1'b0};
                we    = 1'b1;
                waddr = idx(a_reg);
                wdata.parent = b_reg;
                wdata.jump   = (sumd == twice) ? ev_reg.jump : b_reg;
                wdata.depth  = (eu_reg.depth == taj_pkg::DEPTH_MAX) ? taj_pkg::DEPTH_MAX
                                                                    : eu_reg.depth + 10'd1;
                state_next = S_IDLE;
            end
            S_Q_A:
            begin
                da_next = rdata.depth;
                raddr = idx(b_reg);
                state_next = S_RD;
                ret_next = S_Q_B;
            end
            S_Q_B:
            begin
                db_next = rdata.depth;
                // deeper node climbs to the shallower depth
                if (da_reg < rdata.depth)
                begin
                    u_next = b_reg; v_next = a_reg;
                    ck_next = 11'(rdata.depth - da_reg);
                    raddr = idx(b_reg);
                end
                else
                begin
                    u_next = a_reg; v_next = b_reg;
                    ck_next = 11'(da_reg - rdata.depth);
                    raddr = idx(a_reg);
                end
                cmode_next = CL_EQ;
                state_next = S_RD;
                ret_next = S_CL;
            end
            S_CL:
            begin
                eu_next = rdata;
                tmp = u_reg;
                // a depth-zero node is a root and every further step stays on it
                if (ck_reg == '0 || rdata.depth == '0)
                begin
                    // climb finished at u
                    if (cmode_reg == CL_EQ)
                    begin
                        if (idx(u_reg) == idx(v_reg))
                        begin
                            m_next = u_reg;
                            raddr = idx(u_reg);
                            state_next = S_RD;
                            ret_next = S_LM;
                        end
                        else
                        begin
                            rnd_next = '0;
                            raddr = idx(v_reg);
                            state_next = S_RD;
                            ret_next = S_LV;
                        end
                    end
                    else
                    begin
                        pn_next = tmp;
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    raddr = idx(rdata.jump);
                    state_next = S_RD;
                    ret_next = S_CLJ;
                end
            end
            S_CLJ:
            begin
                gain = 11'(eu_reg.depth) - 11'(rdata.depth);
                if (eu_reg.depth > rdata.depth && gain <= ck_reg)
                begin
                    u_next  = eu_reg.jump;
                    ck_next = ck_reg - gain;
                    raddr = idx(eu_reg.jump);
                end
                else
                begin
                    u_next  = eu_reg.parent;
                    ck_next = ck_reg - 11'd1;
                    raddr = idx(eu_reg.parent);
                end
                state_next = S_RD;
                ret_next = S_CL;
            end
            S_LV:
            begin
                ev_next = rdata;
                raddr = idx(u_reg);
                state_next = S_RD;
                ret_next = S_LU;
            end
            S_LU:
            begin
                eu_next = rdata;
                if (rdata.parent == ev_reg.parent || rnd_reg == RW'(MAX_NODES))
                begin
                    m_next = rdata.parent;
                    raddr = idx(rdata.parent);
                    state_next = S_RD;
                    ret_next = S_LM;
                end
                else
                begin
                    rnd_next = rnd_reg + 1'b1;
                    if (rdata.jump != ev_reg.jump)
                    begin
                        u_next = rdata.jump; v_next = ev_reg.jump;
                        raddr = idx(ev_reg.jump);
                    end
                    else
                    begin
                        u_next = rdata.parent; v_next = ev_reg.parent;
                        raddr = idx(ev_reg.parent);
                    end
                    state_next = S_RD;
                    ret_next = S_LV;
                end
            end
            S_LM:
            begin
                lenw = 12'(da_reg) + 12'(db_reg);
                twice = {1'b0, rdata.depth, 1'b0};
                if (lenw < twice)
                begin
                    plen_next = '0;
                end
                else
                begin
                    lenw = lenw - twice;
                    plen_next = lenw[11] ? 11'h7FF : lenw[10:0];
                end
                ej_next = rdata;
                state_next = S_KICK;
            end
            S_KICK:
            begin
                pn_next = '0;
                pv_next = 1'b0;
                if (k_reg <= plen_reg)
                begin
                    pv_next = 1'b1;
                    cmode_next = CL_PATH;
                    up = (da_reg >= ej_reg.depth) ? da_reg - ej_reg.depth : '0;
                    if (da_reg >= ej_reg.depth && 11'(up) >= k_reg)
                    begin
                        u_next = a_reg; ck_next = k_reg;
                        raddr = idx(a_reg);
                    end
                    else
                    begin
                        u_next = b_reg; ck_next = plen_reg - k_reg;
                        raddr = idx(b_reg);
                    end
                    state_next = S_RD;
                    ret_next = S_CL;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                // load the output register once it is empty or freeing now
                if (!ov_reg || out_ready)
                begin
                    ov_next  = 1'b1;
                    oca_next = m_reg;
                    opl_next = plen_reg;
                    opn_next = pn_reg;
                    opv_next = pv_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ret_reg   <= S_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmode_reg <= cmode_next;
        a_reg <= a_next; b_reg <= b_next; k_reg <= k_next;
        u_reg <= u_next; v_reg <= v_next;
        eu_reg <= eu_next; ev_reg <= ev_next; ej_reg <= ej_next;
        da_reg <= da_next; db_reg <= db_next; ck_reg <= ck_next;
        rnd_reg <= rnd_next; m_reg <= m_next; plen_reg <= plen_next;
        pn_reg <= pn_next; pv_reg <= pv_next;
        raddr_reg <= raddr;
        oca_reg <= oca_next; opl_reg <= opl_next;
        opn_reg <= opn_next; opv_reg <= opv_next;
    end

`ifndef SYNTHESIS
    a_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_reg))
        else $error("state not one-hot");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !in_ready)
        else $error("ready while busy");
    a_done_sets_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE) |=> out_valid)
        else $error("result lost");
    a_valid_len: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && path_node_valid) |-> (path_length <= 11'd2046))
        else $error("bad length");
`endif

endmodule
